// ===== src/distance_vector_route_table_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the route table unit.
// ----------------------------------------------------------------------------
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_UNIT_MACROS_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define DVRT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define DVRT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define DVRT_ASSERT(lbl, clk, rstn, prop, msg)
`define DVRT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== src/dvrt_pkg.sv =====
// ----------------------------------------------------------------------------
// dvrt_pkg
// Types and constants shared by the route table controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package dvrt_pkg;

  localparam int unsigned HOP_W = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [4:0]  NODE_COUNT_RST = 5'd16;
  localparam logic [15:0] NO_LINK_RST    = 16'd999;

  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NO_LINK    = 2'd1;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  src_node;
    logic [3:0]  dst_node;
    logic [15:0] link_cost;
  } in_item_t;

  typedef struct packed {
    logic [15:0] path_cost;
    logic [7:0]  hop_count;
    logic        is_done_marker;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic run_start;
    logic load_wr;
    logic q_rd;
    logic ij_rd;
    logic best_init;
    logic k_step;
    logic ij_wr;
    logic out_query;
    logic out_done;
  } dp_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic k_last;
    logic ij_last;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== src/distance_vector_route_table_unit.sv =====
// Load: item captured on transfer, table written in the next cycle; no result.
// Query: entry read in QRD, result registered in QOUT once the output is free.
// Compute: for n nodes, n passes over all (i, j), each one read-add-compare of
//   the shared table ports per intermediate node; done result after that.
// Reset: node_count 16, no_link_value 999; the cost and hop tables hold
//   undefined data until loaded.
// ----------------------------------------------------------------------------
// distance_vector_route_table_unit
// Link-cost table with min-plus relaxation, pair query and config registers.
// ----------------------------------------------------------------------------
`default_nettype none

module distance_vector_route_table_unit #(
  parameter int unsigned MAX_NODES = 16,
  parameter int unsigned COST_BITS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire dvrt_pkg::in_item_t                  in_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output dvrt_pkg::out_item_t                      out_data_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [dvrt_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [dvrt_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  logic [4:0]  node_count_q;
  logic [15:0] no_link_q;

  dvrt_pkg::dp_cmd_t dp_cmd;
  dvrt_pkg::dp_sts_t dp_sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= dvrt_pkg::NODE_COUNT_RST;
      no_link_q    <= dvrt_pkg::NO_LINK_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dvrt_pkg::REG_NODE_COUNT: node_count_q <= cfg_data_i[4:0];
        dvrt_pkg::REG_NO_LINK:    no_link_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  dvrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (in_data_i.command),
    .cmd_o      (dp_cmd),
    .sts_i      (dp_sts)
  );

  dvrt_datapath #(
    .MAX_NODES (MAX_NODES),
    .COST_BITS (COST_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .sts_o        (dp_sts),
    .in_data_i    (in_data_i),
    .node_count_i (node_count_q),
    .no_link_i    (no_link_q),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire

// ===== src/dvrt_datapath.sv =====
// ----------------------------------------------------------------------------
// dvrt_datapath
// Cost and hop tables, loop counters, min-plus compare unit and result
// register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "distance_vector_route_table_unit_macros.svh"

module dvrt_datapath #(
  parameter int unsigned MAX_NODES = 16,
  parameter int unsigned COST_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dvrt_pkg::dp_cmd_t  cmd_i,
  output dvrt_pkg::dp_sts_t       sts_o,
  input  wire dvrt_pkg::in_item_t in_data_i,
  input  wire logic [4:0]         node_count_i,
  input  wire logic [15:0]        no_link_i,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output dvrt_pkg::out_item_t     out_data_o
);

  localparam int unsigned IDX_W  = $clog2(MAX_NODES);
  localparam int unsigned CNT_W  = $clog2(MAX_NODES + 1);
  localparam int unsigned ADDR_W = 2 * IDX_W;
  localparam int unsigned DEPTH  = 1 << ADDR_W;
  localparam int unsigned HOP_W  = dvrt_pkg::HOP_W;

  logic [COST_BITS-1:0] cost_mem [DEPTH];
  logic [HOP_W-1:0]     hop_mem  [DEPTH];

  dvrt_pkg::in_item_t   item_q;
  logic                 inside_q;
  logic [IDX_W-1:0]     pass_q, i_q, j_q, k_q;
  logic [COST_BITS-1:0] rd_cost_a_q, rd_cost_b_q;
  logic [HOP_W-1:0]     rd_hop_a_q, rd_hop_b_q;
  logic                 fwd_a_q, fwd_b_q, cmp_v_q;
  logic [COST_BITS-1:0] best_q;
  logic [HOP_W-1:0]     best_hop_q;
  logic                 out_valid_q;
  dvrt_pkg::out_item_t  out_data_q;

  logic [CNT_W-1:0]     n_eff;
  logic [IDX_W-1:0]     n_m1;
  logic [IDX_W-1:0]     src_idx, dst_idx;
  logic [ADDR_W-1:0]    addr_a, addr_b, waddr;
  logic                 rd_a_en, we;
  logic [COST_BITS-1:0] wcost, op_a, op_b, sum_sat;
  logic [HOP_W-1:0]     whop, hop_a, hop_b, hop_sat;
  logic [COST_BITS:0]   sum_w;
  logic [HOP_W:0]       hop_w;
  logic                 better;

  assign n_eff   = (32'(node_count_i) > MAX_NODES) ? CNT_W'(MAX_NODES) : CNT_W'(node_count_i);
  assign n_m1    = IDX_W'(n_eff - CNT_W'(1));
  assign src_idx = IDX_W'(item_q.src_node);
  assign dst_idx = IDX_W'(item_q.dst_node);

  always_comb begin
    if (cmd_i.q_rd) begin
      addr_a = {src_idx, dst_idx};
    end else if (cmd_i.ij_rd) begin
      addr_a = {i_q, j_q};
    end else begin
      addr_a = {i_q, k_q};
    end
  end
  assign addr_b  = {k_q, j_q};
  assign rd_a_en = cmd_i.q_rd | cmd_i.ij_rd | cmd_i.k_step;

  always_comb begin
    if (cmd_i.ij_wr) begin
      we    = 1'b1;
      waddr = {i_q, j_q};
      wcost = best_q;
      whop  = best_hop_q;
    end else begin
      we    = cmd_i.load_wr & inside_q;
      waddr = {src_idx, dst_idx};
      wcost = COST_BITS'(item_q.link_cost);
      whop  = ((item_q.link_cost != 16'd0) && (item_q.link_cost != no_link_i))
              ? HOP_W'(1) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      cost_mem[waddr] <= wcost;
      hop_mem[waddr]  <= whop;
    end
    if (rd_a_en) begin
      rd_cost_a_q <= cost_mem[addr_a];
      rd_hop_a_q  <= hop_mem[addr_a];
    end
    if (cmd_i.k_step) begin
      rd_cost_b_q <= cost_mem[addr_b];
      rd_hop_b_q  <= hop_mem[addr_b];
    end
  end

  // forward the running minimum where the operand is the entry being relaxed
  assign op_a    = fwd_a_q ? best_q : rd_cost_a_q;
  assign op_b    = fwd_b_q ? best_q : rd_cost_b_q;
  assign hop_a   = fwd_a_q ? best_hop_q : rd_hop_a_q;
  assign hop_b   = fwd_b_q ? best_hop_q : rd_hop_b_q;
  assign sum_w   = {1'b0, op_a} + {1'b0, op_b};
  assign sum_sat = sum_w[COST_BITS] ? '1 : sum_w[COST_BITS-1:0];
  assign hop_w   = {1'b0, hop_a} + {1'b0, hop_b};
  assign hop_sat = hop_w[HOP_W] ? '1 : hop_w[HOP_W-1:0];
  assign better  = best_q > sum_sat;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q   <= in_data_i;
      inside_q <= (32'(in_data_i.src_node) < MAX_NODES) &&
                  (32'(in_data_i.dst_node) < MAX_NODES);
    end
    if (cmd_i.k_step) begin
      fwd_a_q <= (k_q == j_q);
      fwd_b_q <= (k_q == i_q);
    end
    if (cmd_i.best_init) begin
      best_q     <= rd_cost_a_q;
      best_hop_q <= rd_hop_a_q;
    end else if (cmp_v_q && better) begin
      best_q     <= sum_sat;
      best_hop_q <= hop_sat;
    end
    if (cmd_i.out_query) begin
      out_data_q.path_cost      <= inside_q ? 16'(rd_cost_a_q) : 16'd0;
      out_data_q.hop_count      <= inside_q ? rd_hop_a_q : '0;
      out_data_q.is_done_marker <= 1'b0;
    end else if (cmd_i.out_done) begin
      out_data_q.path_cost      <= 16'd0;
      out_data_q.hop_count      <= '0;
      out_data_q.is_done_marker <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q      <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      cmp_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cmp_v_q <= cmd_i.k_step;
      if (cmd_i.run_start) begin
        pass_q <= '0;
        i_q    <= '0;
        j_q    <= '0;
      end else if (cmd_i.ij_wr) begin
        if (j_q != n_m1) begin
          j_q <= j_q + IDX_W'(1);
        end else begin
          j_q <= '0;
          if (i_q != n_m1) begin
            i_q <= i_q + IDX_W'(1);
          end else begin
            i_q    <= '0;
            pass_q <= pass_q + IDX_W'(1);
          end
        end
      end
      if (cmd_i.ij_rd) begin
        k_q <= '0;
      end else if (cmd_i.k_step) begin
        k_q <= k_q + IDX_W'(1);
      end
      if (cmd_i.out_query || cmd_i.out_done) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.n_zero   = (n_eff == '0);
  assign sts_o.k_last   = (k_q == n_m1);
  assign sts_o.ij_last  = (pass_q == n_m1) && (i_q == n_m1) && (j_q == n_m1);
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_data_q;

  `DVRT_ASSERT_NEXT(a_best_monotonic, clk_i, rst_ni, cmp_v_q && !cmd_i.best_init, best_q <= $past(best_q), "running minimum increased")

endmodule

`default_nettype wire

// ===== src/dvrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// dvrt_ctrl
// Command sequencer: load, query and the pass/row/column/intermediate
// relaxation loop.
// ----------------------------------------------------------------------------
`default_nettype none
`include "distance_vector_route_table_unit_macros.svh"

module dvrt_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        command_i,
  output dvrt_pkg::dp_cmd_t      cmd_o,
  input  wire dvrt_pkg::dp_sts_t sts_i
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_QRD,
    ST_QOUT,
    ST_IJ,
    ST_INIT,
    ST_K,
    ST_CMP,
    ST_WR,
    ST_DONE
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          case (command_i)
            dvrt_pkg::CMD_LOAD: state_d = ST_LOAD;
            dvrt_pkg::CMD_RUN: begin
              cmd_o.run_start = 1'b1;
              state_d = sts_i.n_zero ? ST_DONE : ST_IJ;
            end
            dvrt_pkg::CMD_QUERY: state_d = ST_QRD;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_LOAD: begin
        cmd_o.load_wr = 1'b1;
        state_d = ST_IDLE;
      end
      ST_QRD: begin
        cmd_o.q_rd = 1'b1;
        state_d = ST_QOUT;
      end
      ST_QOUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_query = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_IJ: begin
        cmd_o.ij_rd = 1'b1;
        state_d = ST_INIT;
      end
      ST_INIT: begin
        cmd_o.best_init = 1'b1;
        state_d = ST_K;
      end
      ST_K: begin
        cmd_o.k_step = 1'b1;
        if (sts_i.k_last) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: state_d = ST_WR;
      ST_WR: begin
        cmd_o.ij_wr = 1'b1;
        state_d = sts_i.ij_last ? ST_DONE : ST_IJ;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_done = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `DVRT_ASSERT(a_mem_access_onehot, clk_i, rst_ni, $onehot0({cmd_o.load_wr, cmd_o.q_rd, cmd_o.ij_rd, cmd_o.k_step, cmd_o.ij_wr}), "overlapping table accesses")
  `DVRT_ASSERT_NEXT(a_k_stops, clk_i, rst_ni, cmd_o.k_step && sts_i.k_last, !cmd_o.k_step, "intermediate loop overran")
  `DVRT_ASSERT_NEXT(a_init_after_read, clk_i, rst_ni, cmd_o.ij_rd, cmd_o.best_init, "minimum not seeded after entry read")
  `DVRT_ASSERT(a_result_slot_free, clk_i, rst_ni, !(cmd_o.out_query || cmd_o.out_done) || sts_i.out_free, "result register overwritten")

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the route table unit. A directed table covers the
// reset registers, cost and index extremes, the no-link marker and ignored
// commands. Random phases follow: matrix loads, relaxation runs and pair
// queries over changing node counts. Answers come from a min-plus table model
// in the bench or typed plan rows, with random idling applied on both sides.
// ----------------------------------------------------------------------------
module tb;
  import dvrt_pkg::*;

  localparam int NODES_MAX = 16;
  localparam int RANDOM_ITEMS = 90;
  localparam int QUIET_CYCLES = 8;
  localparam int HOLD_OFF_CYCLES = 250;
  localparam int STALL_LIMIT = 250000;
  localparam int PLAN_LEN = 35;
  localparam logic [1:0] CMD_NOP = 2'd3;

  localparam out_item_t NO_ANSWER = '0;
  localparam out_item_t DONE_ANSWER = '{16'd0, 8'd0, 1'b1};

  typedef enum logic [1:0] {ROW_ITEM, ROW_CFG, ROW_FILL} row_kind_e;
  typedef enum logic [1:0] {RX_OPEN, RX_BUSY, RX_CHOKED} rx_mode_e;

  typedef struct {
    row_kind_e             kind;
    in_item_t              item;
    bit                    typed;
    out_item_t             want;
    logic [CFG_IDX_W-1:0]  widx;
    logic [CFG_DATA_W-1:0] wdata;
  } row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_item_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_item_t             out_data_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  logic [15:0] cost_tbl [NODES_MAX*NODES_MAX];
  logic [7:0]  hops_tbl [NODES_MAX*NODES_MAX];
  logic [4:0]  node_cfg = NODE_COUNT_RST;
  logic [15:0] no_link_cfg = NO_LINK_RST;
  out_item_t   pending_answers [$];
  int          errors = 0;
  int          items_sent = 0;
  int          burst_left = 0;
  int          stall_cycles = 0;
  bit          hold_off_req = 1'b0;
  row_t        plan [PLAN_LEN];

  distance_vector_route_table_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  function automatic bit route_model_step(input in_item_t it, output out_item_t ans);
    int idx, n, p, i, j, k, ij, ik, kj;
    logic [16:0] sum;
    logic [15:0] best;
    logic [8:0]  hsum;
    idx = int'(it.src_node) * NODES_MAX + int'(it.dst_node);
    ans = NO_ANSWER;
    case (it.command)
      CMD_LOAD: begin
        cost_tbl[idx] = it.link_cost;
        hops_tbl[idx] = (it.link_cost != '0 && it.link_cost != no_link_cfg) ? 8'd1 : 8'd0;
        return 1'b0;
      end
      CMD_RUN: begin
        n = (node_cfg > NODES_MAX) ? NODES_MAX : int'(node_cfg);
        for (p = 0; p < n; p++) begin
          for (i = 0; i < n; i++) begin
            for (j = 0; j < n; j++) begin
              ij = i * NODES_MAX + j;
              best = cost_tbl[ij];
              for (k = 0; k < n; k++) begin
                ik = i * NODES_MAX + k;
                kj = k * NODES_MAX + j;
                sum = cost_tbl[ik] + cost_tbl[kj];
                if (sum > 17'h0FFFF) sum = 17'h0FFFF;
                if (sum < {1'b0, best}) begin
                  hsum = hops_tbl[ik] + hops_tbl[kj];
                  cost_tbl[ij] = sum[15:0];
                  hops_tbl[ij] = (hsum > 9'd255) ? 8'hFF : hsum[7:0];
                  best = sum[15:0];
                end
              end
            end
          end
        end
        ans = DONE_ANSWER;
        return 1'b1;
      end
      CMD_QUERY: begin
        ans = '{cost_tbl[idx], hops_tbl[idx], 1'b0};
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [15:0] pick_cost();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1, 2:    return no_link_cfg;
      3:       return 16'($urandom_range(30000, 65535));
      4:       return 16'($urandom);
      default: return 16'($urandom_range(1, 40));
    endcase
  endfunction

  function automatic logic [3:0] pick_node(input int n);
    if (n == 0) return 4'd0;
    return 4'($urandom_range(0, (n > NODES_MAX) ? NODES_MAX - 1 : n - 1));
  endfunction

  task automatic offer_cmd(input in_item_t it, input bit typed = 1'b0,
                           input out_item_t want = NO_ANSWER);
    out_item_t ans;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    if (route_model_step(it, ans)) pending_answers.push_back(typed ? want : ans);
    if (it.command != CMD_NOP) items_sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_NODE_COUNT) node_cfg = data[4:0];
    else if (idx == REG_NO_LINK) no_link_cfg = data;
  endtask

  task automatic fill_matrix(input int keep_pct);
    int n, i, j;
    n = (node_cfg > NODES_MAX) ? NODES_MAX : int'(node_cfg);
    for (i = 0; i < n; i++) begin
      for (j = 0; j < n; j++) begin
        if ($urandom_range(1, 100) <= keep_pct) begin
          offer_cmd('{CMD_LOAD, 4'(i), 4'(j), pick_cost()});
        end
      end
    end
  endtask

  always @(posedge clk_i) begin : answer_check
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected result: path_cost %0d hop_count %0d is_done_marker %0b",
               out_data_o.path_cost, out_data_o.hop_count, out_data_o.is_done_marker);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        if (out_data_o.path_cost !== want.path_cost) begin
          $error("path_cost: expected %0d, got %0d", want.path_cost, out_data_o.path_cost);
          errors++;
        end
        if (out_data_o.hop_count !== want.hop_count) begin
          $error("hop_count: expected %0d, got %0d", want.hop_count, out_data_o.hop_count);
          errors++;
        end
        if (out_data_o.is_done_marker !== want.is_done_marker) begin
          $error("is_done_marker: expected %0b, got %0b", want.is_done_marker,
                 out_data_o.is_done_marker);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[distance_vector_route_table_unit] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : rx_side
    rx_mode_e mode;
    int       mode_left;
    mode = RX_OPEN;
    mode_left = 0;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (mode)
          RX_OPEN: out_ready_i <= 1'b1;
          RX_BUSY: out_ready_i <= ($urandom_range(0, 3) != 0);
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    int n, phase;
    plan = '{
      '{ROW_ITEM, '{CMD_LOAD, 4'd0, 4'd0, 16'd0}, 1'b0, NO_ANSWER, '0, '0},
      '{ROW_ITEM, '{CMD_QUERY, 4'd0, 4'd0, 16'd0}, 1'b1, '{16'd0, 8'd0, 1'b0}, '0, '0},
      '{ROW_ITEM, '{CMD_LOAD, 4'd0, 4'd1, 16'd999}, 1'b0, NO_ANSWER, '0, '0},
      '{ROW_ITEM, '{CMD_QUERY, 4'd0, 4'd1, 16'd0}, 1'b1, '{16'd999, 8'd0, 1'b0}, '0, '0},
      '{ROW_ITEM, '{CMD_LOAD, 4'd15, 4'd15, 16'hFFFF}, 1'b0, NO_ANSWER, '0, '0},
      '{ROW_ITEM, '{CMD_QUERY, 4'd15, 4'd15, 16'd0}, 1'b1, '{16'hFFFF, 8'd1, 1'b0}, '0, '0},
      '{ROW_ITEM, '{CMD_NOP, 4'd15, 4'd15, 16'hFFFF}, 1'b0, NO_ANSWER, '0, '0},
      '{ROW_ITEM, '{CMD_QUERY, 4'd15, 4'd15, 16'd0}, 1'b1, '{16'hFFFF, 8'd1, 1'b0}, '0, '0},
      '{ROW_ITEM, '{CMD_LOAD, 4'd15, 4'd0, 16'd1}, 1'b0, NO_ANSWER, '0, '0},
      '{ROW_ITEM, '{CMD_QUERY, 4'd15, 4'd0, 16'd0}, 1'b1, '{16'd1, 8'd1, 1'b0}, '0, '0},
      '{ROW_CFG, '0, 1'b0, NO_ANSWER, REG_NODE_COUNT, 16'h0004},
      '{ROW_FILL, '0, 1'b0, NO_ANSWER, '0, '0},
      '{ROW_ITEM, '{CMD_RUN, 4'd0, 4'd0, 16'd0}, 1'b1, DONE_ANSWER, '0, '0},
      '{ROW_ITEM, '{CMD_QUERY, 4'd3, 4'd2, 16'd0}, 1'b0, NO_ANSWER, '0, '0},
      '{ROW_ITEM, '{CMD_QUERY, 4'd15, 4'd15, 16'd0}, 1'b0, NO_ANSWER, '0, '0},
      '{ROW_CFG, '0, 1'b0, NO_ANSWER, REG_NODE_COUNT, 16'h0000},
      '{ROW_ITEM, '{CMD_RUN, 4'd15, 4'd15, 16'hFFFF}, 1'b1, DONE_ANSWER, '0, '0},
      '{ROW_CFG, '0, 1'b0, NO_ANSWER, REG_NO_LINK, 16'h0000},
      '{ROW_ITEM, '{CMD_LOAD, 4'd2, 4'd2, 16'd0}, 1'b0, NO_ANSWER, '0, '0},
      '{ROW_ITEM, '{CMD_QUERY, 4'd2, 4'd2, 16'd0}, 1'b1, '{16'd0, 8'd0, 1'b0}, '0, '0},
      '{ROW_ITEM, '{CMD_LOAD, 4'd2, 4'd4, 16'd5}, 1'b0, NO_ANSWER, '0, '0},
      '{ROW_ITEM, '{CMD_QUERY, 4'd2, 4'd4, 16'd0}, 1'b1, '{16'd5, 8'd1, 1'b0}, '0, '0},
      '{ROW_CFG, '0, 1'b0, NO_ANSWER, REG_NO_LINK, 16'hFFFF},
      '{ROW_ITEM, '{CMD_LOAD, 4'd2, 4'd3, 16'hFFFF}, 1'b0, NO_ANSWER, '0, '0},
      '{ROW_ITEM, '{CMD_QUERY, 4'd2, 4'd3, 16'd0}, 1'b1, '{16'hFFFF, 8'd0, 1'b0}, '0, '0},
      '{ROW_CFG, '0, 1'b0, NO_ANSWER, REG_NODE_COUNT, 16'h0001},
      '{ROW_ITEM, '{CMD_RUN, 4'd0, 4'd0, 16'd0}, 1'b1, DONE_ANSWER, '0, '0},
      '{ROW_ITEM, '{CMD_QUERY, 4'd0, 4'd0, 16'd0}, 1'b0, NO_ANSWER, '0, '0},
      '{ROW_CFG, '0, 1'b0, NO_ANSWER, REG_NODE_COUNT, 16'hFFE2},
      '{ROW_FILL, '0, 1'b0, NO_ANSWER, '0, '0},
      '{ROW_ITEM, '{CMD_RUN, 4'd0, 4'd0, 16'd0}, 1'b1, DONE_ANSWER, '0, '0},
      '{ROW_ITEM, '{CMD_QUERY, 4'd0, 4'd1, 16'd0}, 1'b0, NO_ANSWER, '0, '0},
      '{ROW_CFG, '0, 1'b0, NO_ANSWER, REG_NODE_COUNT, 16'h0004},
      '{ROW_ITEM, '{CMD_RUN, 4'd0, 4'd0, 16'd0}, 1'b1, DONE_ANSWER, '0, '0},
      '{ROW_ITEM, '{CMD_QUERY, 4'd15, 4'd0, 16'd0}, 1'b0, NO_ANSWER, '0, '0}
    };
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[r]) begin
      case (plan[r].kind)
        ROW_CFG: begin
          settle();
          write_reg(plan[r].widx, plan[r].wdata);
        end
        ROW_FILL: fill_matrix(100);
        default: offer_cmd(plan[r].item, plan[r].typed, plan[r].want);
      endcase
    end

    items_sent = 0;
    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      settle();
      n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
      write_reg(REG_NODE_COUNT, {11'($urandom), 5'(n)});
      write_reg(REG_NO_LINK, ($urandom_range(0, 3) == 0) ? NO_LINK_RST
                                                          : 16'($urandom_range(1, 40)));
      fill_matrix(100);
      repeat ($urandom_range(0, 3)) begin
        offer_cmd('{($urandom_range(0, 1) == 0) ? CMD_NOP : CMD_LOAD, 4'($urandom),
                    4'($urandom), 16'($urandom)});
      end
      if (phase == 1) hold_off_req = 1'b1;
      repeat ((phase == 1) ? 12 : $urandom_range(0, 3)) begin
        offer_cmd('{CMD_QUERY, pick_node(n), pick_node(n), 16'($urandom)});
      end
      offer_cmd('{CMD_RUN, 4'($urandom), 4'($urandom), 16'($urandom)});
      repeat ($urandom_range(2, 5)) begin
        offer_cmd('{CMD_QUERY, pick_node(n), pick_node(n), 16'($urandom)});
      end
      phase++;
    end

    settle();
    if (errors == 0) begin
      $display("[distance_vector_route_table_unit] OK");
    end else begin
      $display("[distance_vector_route_table_unit] ERROR");
    end
    $finish;
  end

endmodule
